// ===== src/psb_pkg.sv =====
// ----------------------------------------------------------------------------
// Power sequencer package
// Shared types and constants for the power sequencer with power button.
// ----------------------------------------------------------------------------
package psb_pkg;

	localparam int unsigned PERIOD_W = 10;
	localparam int unsigned TICKS_W  = 16;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned STATE_W = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_PERIOD  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POWERWAIT      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BOOTWAIT       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SHUTDOWN       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_POWEROFF       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE           = 3'd6;

	localparam int unsigned MS_PER_SEC = 1000;

	localparam logic [PERIOD_W-1:0] BUTTON_PERIOD_RST = PERIOD_W'(10);
	localparam logic [TICKS_W-1:0]  LONG_PRESS_RST    = TICKS_W'(2000);
	localparam logic [TICKS_W-1:0]  POWERWAIT_RST     = TICKS_W'(1 * MS_PER_SEC);
	localparam logic [TICKS_W-1:0]  BOOTWAIT_RST      = TICKS_W'(30 * MS_PER_SEC);
	localparam logic [TICKS_W-1:0]  SHUTDOWN_RST      = TICKS_W'(30 * MS_PER_SEC);
	localparam logic [TICKS_W-1:0]  POWEROFF_RST      = TICKS_W'(30 * MS_PER_SEC);
	localparam logic [TICKS_W-1:0]  IDLE_RST          = TICKS_W'(5 * MS_PER_SEC);

	typedef struct packed {
		logic tap;
		logic hold;
	} press_t;

	typedef struct packed {
		logic               enable_out;
		logic               shutdown_out;
		logic               sleep_request;
		logic [STATE_W-1:0] state_code;
		logic               short_press_seen;
		logic               long_press_seen;
	} result_t;

endpackage

// ===== src/psb_button.sv =====
// ----------------------------------------------------------------------------
// Power button sampler
// Samples the button once per period and reports short and long presses.
// ----------------------------------------------------------------------------
module psb_button import psb_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                button_down,
	input  logic [PERIOD_W-1:0] button_period,
	input  logic [TICKS_W-1:0]  long_press_ticks,
	output press_t              press
);

	logic [PERIOD_W-1:0] poll_q, poll_inc, poll_d;
	logic [TICKS_W-1:0]  held_q, held_inc, held_d;
	logic                ignore_q, ignore_d;
	logic                last_q, last_d;
	logic                sample, pressed, released;

	always_comb begin
		poll_inc = (&poll_q) ? poll_q : poll_q + PERIOD_W'(1);
		held_inc = (&held_q) ? held_q : held_q + TICKS_W'(1);
		sample   = poll_inc > button_period;
		pressed  = button_down && !last_q;
		released = !button_down && last_q;
		poll_d   = poll_inc;
		held_d   = held_inc;
		ignore_d = ignore_q;
		last_d   = last_q;
		press    = '0;
		if (sample) begin
			poll_d = '0;
			last_d = button_down;
			if (ignore_q) begin
				if (released) begin
					ignore_d = 1'b0;
				end
			end else if (pressed) begin
				held_d = '0;
			end else if (released) begin
				press.tap = 1'b1;
			end else if (button_down && held_inc > long_press_ticks) begin
				press.hold = 1'b1;
				ignore_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_q   <= '0;
			held_q   <= '0;
			ignore_q <= 1'b0;
			last_q   <= 1'b0;
		end else if (step) begin
			poll_q   <= poll_d;
			held_q   <= held_d;
			ignore_q <= ignore_d;
			last_q   <= last_d;
		end
	end

endmodule

// ===== src/power_sequencer_with_button.sv =====
// ----------------------------------------------------------------------------
// Power sequencer with power button
// Each input transaction is one millisecond tick carrying the sampled USB
// power, button and boot pin levels. Each tick produces exactly one output
// transaction with the enable and shutdown levels, a sleep request pulse,
// the sequencer state after the tick and the press events seen on it.
// The cfg channel writes the seven timing registers by index; it is always
// ready and should only be used while no tick is in flight. Indexes beyond
// the last register are ignored.
// A tick is processed in the cycle it is accepted and its result is
// registered. One tick is accepted every cycle while the skid register is
// empty: the result register is backed by a one-entry skid register, so a
// stalled receiver holds off input only once both entries are full.
// Reset puts the sequencer in its start state, clears out_valid, the enable and
// shutdown state and all elapsed counters, and loads the default timing values.
// ----------------------------------------------------------------------------
module power_sequencer_with_button import psb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  usb_level,
	input  logic                  button_down,
	input  logic                  boot_level,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  enable_out,
	output logic                  shutdown_out,
	output logic                  sleep_request,
	output logic [STATE_W-1:0]    state_code,
	output logic                  short_press_seen,
	output logic                  long_press_seen,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [STATE_W-1:0] {
		ST_START = 4'd0,
		ST_PW0   = 4'd1,
		ST_PW1   = 4'd2,
		ST_PON   = 4'd3,
		ST_BW0   = 4'd4,
		ST_BW1   = 4'd5,
		ST_BOOT  = 4'd6,
		ST_SD0   = 4'd7,
		ST_SD1   = 4'd8,
		ST_PO0   = 4'd9,
		ST_PO1   = 4'd10,
		ST_PO2   = 4'd11,
		ST_I0    = 4'd12,
		ST_I1    = 4'd13,
		ST_I2    = 4'd14
	} state_t;

	logic [PERIOD_W-1:0] button_period_q;
	logic [TICKS_W-1:0]  long_press_q, powerwait_q, bootwait_q;
	logic [TICKS_W-1:0]  shutdown_q, poweroff_q, idle_q;

	state_t              state_q, state_d, state_cur;
	logic [TICKS_W-1:0]  phase_q, phase_inc, phase_d;
	logic                last_usb_q;
	logic                enable_q, enable_d;
	logic                shutdown_q_r, shutdown_d;
	logic                sleep_d;
	logic                usb_rose, usb_fell, boot_asserted;
	logic                accept;
	press_t              press;
	result_t             res_d, out_q, skid_q;
	logic                out_valid_q, skid_valid_q, load_out;

	assign cfg_ready = 1'b1;
	assign in_ready  = !skid_valid_q;
	assign accept    = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			button_period_q <= BUTTON_PERIOD_RST;
			long_press_q    <= LONG_PRESS_RST;
			powerwait_q     <= POWERWAIT_RST;
			bootwait_q      <= BOOTWAIT_RST;
			shutdown_q      <= SHUTDOWN_RST;
			poweroff_q      <= POWEROFF_RST;
			idle_q          <= IDLE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_BUTTON_PERIOD: button_period_q <= cfg_data[PERIOD_W-1:0];
				CFG_LONG_PRESS:    long_press_q    <= cfg_data;
				CFG_POWERWAIT:     powerwait_q     <= cfg_data;
				CFG_BOOTWAIT:      bootwait_q      <= cfg_data;
				CFG_SHUTDOWN:      shutdown_q      <= cfg_data;
				CFG_POWEROFF:      poweroff_q      <= cfg_data;
				CFG_IDLE:          idle_q          <= cfg_data;
				default: ;
			endcase
		end
	end

	psb_button u_button (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (accept),
		.button_down      (button_down),
		.button_period    (button_period_q),
		.long_press_ticks (long_press_q),
		.press            (press)
	);

	always_comb begin
		phase_inc     = (&phase_q) ? phase_q : phase_q + TICKS_W'(1);
		usb_rose      = usb_level && !last_usb_q;
		usb_fell      = !usb_level && last_usb_q;
		boot_asserted = !boot_level;
		state_cur     = press.hold ? ST_PO2 : state_q;
		state_d       = state_cur;
		phase_d       = phase_inc;
		enable_d      = enable_q;
		shutdown_d    = shutdown_q_r;
		sleep_d       = 1'b0;
		unique case (state_cur)
			ST_PW0: begin
				phase_d = '0;
				state_d = ST_PW1;
			end
			ST_PW1: begin
				if (usb_fell) begin
					state_d = ST_PO2;
				end else if (phase_inc > powerwait_q) begin
					state_d = ST_PON;
				end
			end
			ST_PON: begin
				enable_d = 1'b1;
				state_d  = ST_BW0;
			end
			ST_BW0: begin
				phase_d = '0;
				state_d = ST_BW1;
			end
			ST_BW1: begin
				if (phase_inc > bootwait_q) begin
					state_d = ST_PO2;
				end else if (boot_asserted) begin
					state_d = ST_BOOT;
				end
			end
			ST_BOOT: begin
				if (press.tap || usb_fell) begin
					state_d = ST_SD0;
				end else if (!boot_asserted) begin
					state_d = ST_PO0;
				end
			end
			ST_SD0: begin
				shutdown_d = 1'b1;
				phase_d    = '0;
				state_d    = ST_SD1;
			end
			ST_SD1: begin
				if (phase_inc > shutdown_q || !boot_asserted) begin
					state_d = ST_PO0;
				end
			end
			ST_PO0: begin
				// The elapsed count restarts at zero, so the timeout cannot fire here.
				shutdown_d = 1'b0;
				phase_d    = '0;
				state_d    = boot_asserted ? ST_BOOT : ST_PO1;
			end
			ST_PO1: begin
				if (phase_inc > poweroff_q) begin
					state_d = ST_PO2;
				end else if (boot_asserted) begin
					state_d = ST_BOOT;
				end
			end
			ST_PO2: begin
				enable_d   = 1'b0;
				shutdown_d = 1'b0;
				state_d    = ST_I0;
			end
			ST_I0, ST_I1: begin
				sleep_d = (state_cur == ST_I0);
				phase_d = '0;
				if ((press.tap && usb_level) || usb_rose) begin
					state_d = ST_PON;
				end else begin
					state_d = ST_I2;
				end
			end
			ST_I2: begin
				if (phase_inc > idle_q) begin
					state_d = ST_I0;
				end else if ((press.tap && usb_level) || usb_rose) begin
					state_d = ST_PON;
				end
			end
			default: begin
				state_d = usb_level ? ST_PW0 : ST_PO2;
			end
		endcase

		res_d.enable_out       = enable_d;
		res_d.shutdown_out     = shutdown_d;
		res_d.sleep_request    = sleep_d;
		res_d.state_code       = state_d;
		res_d.short_press_seen = press.tap;
		res_d.long_press_seen  = press.hold;
	end

	assign load_out = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_START;
			phase_q      <= '0;
			last_usb_q   <= 1'b0;
			enable_q     <= 1'b0;
			shutdown_q_r <= 1'b0;
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				state_q      <= state_d;
				phase_q      <= phase_d;
				last_usb_q   <= usb_level;
				enable_q     <= enable_d;
				shutdown_q_r <= shutdown_d;
			end
			if (load_out) begin
				out_valid_q  <= skid_valid_q || accept;
				skid_valid_q <= 1'b0;
			end else if (accept) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= skid_valid_q ? skid_q : res_d;
		end else if (accept) begin
			skid_q <= res_d;
		end
	end

	assign out_valid        = out_valid_q;
	assign enable_out       = out_q.enable_out;
	assign shutdown_out     = out_q.shutdown_out;
	assign sleep_request    = out_q.sleep_request;
	assign state_code       = out_q.state_code;
	assign short_press_seen = out_q.short_press_seen;
	assign long_press_seen  = out_q.long_press_seen;

endmodule

// ===== src/psb_checker.sv =====
// ----------------------------------------------------------------------------
// Power sequencer port checker
// Watches the top-level ports for output protocol and sequencing rules.
// ----------------------------------------------------------------------------
module psb_props (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic enable_out,
	input logic shutdown_out,
	input logic sleep_request,
	input logic short_press_seen,
	input logic long_press_seen
);

	// A stalled output transaction stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output transaction dropped while stalled");

	// A long press always leaves the power path off.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && long_press_seen |-> !enable_out && !shutdown_out && !short_press_seen)
		else $error("long press did not force power off");

	// A shutdown request is only raised while power is enabled.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && shutdown_out |-> enable_out)
		else $error("shutdown requested with power disabled");

	// Sleep is only requested with the power path off.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sleep_request |-> !enable_out && !shutdown_out)
		else $error("sleep requested with power enabled");

endmodule

bind power_sequencer_with_button psb_props u_psb_props (.*);

// ===== tb/psb_checker.sv =====
// ----------------------------------------------------------------------------
// Power sequencer checker
// Watches the tick, result and register write channels of the power
// sequencer. It keeps its own model of the sequencer, predicts the result of
// every accepted tick and compares each accepted result against the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------
module psb_checker import psb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic                  usb_level,
	input  logic                  button_down,
	input  logic                  boot_level,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic                  enable_out,
	input  logic                  shutdown_out,
	input  logic                  sleep_request,
	input  logic [STATE_W-1:0]    state_code,
	input  logic                  short_press_seen,
	input  logic                  long_press_seen,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int unsigned           errors,
	output int unsigned           pending
);

	typedef enum logic [STATE_W-1:0] {
		SEQ_START, SEQ_PW0, SEQ_PW1, SEQ_PON, SEQ_BW0, SEQ_BW1, SEQ_BOOT, SEQ_SD0,
		SEQ_SD1, SEQ_PO0, SEQ_PO1, SEQ_PO2, SEQ_IDLE0, SEQ_IDLE1, SEQ_IDLE2, SEQ_UNUSED
	} seq_state_t;

	logic [PERIOD_W-1:0] period_reg;
	logic [TICKS_W-1:0]  long_reg, powerwait_reg, bootwait_reg;
	logic [TICKS_W-1:0]  shutdown_reg, poweroff_reg, idle_reg;

	seq_state_t          seq_state;
	logic [TICKS_W-1:0]  phase_cnt, held_cnt;
	logic [PERIOD_W-1:0] poll_cnt;
	logic                ignore_btn, btn_prev, usb_prev, enable_q, shutdown_q;

	result_t             expected_q[$];

	initial errors = 0;

	task automatic reset_sequencer();
		period_reg    = BUTTON_PERIOD_RST;
		long_reg      = LONG_PRESS_RST;
		powerwait_reg = POWERWAIT_RST;
		bootwait_reg  = BOOTWAIT_RST;
		shutdown_reg  = SHUTDOWN_RST;
		poweroff_reg  = POWEROFF_RST;
		idle_reg      = IDLE_RST;
		seq_state     = SEQ_START;
		phase_cnt     = '0;
		held_cnt      = '0;
		poll_cnt      = '0;
		ignore_btn    = 1'b0;
		btn_prev      = 1'b0;
		usb_prev      = 1'b0;
		enable_q      = 1'b0;
		shutdown_q    = 1'b0;
	endtask

	task automatic predict_tick(input logic usb, input logic btn, input logic boot,
			output result_t res);
		logic boot_on, usb_rise, usb_fall, pressed, released;
		logic short_p, long_p, sleep_p;
		boot_on = !boot;
		short_p = 1'b0;
		long_p  = 1'b0;
		sleep_p = 1'b0;

		if (phase_cnt != '1) phase_cnt = phase_cnt + 1'b1;
		if (held_cnt != '1) held_cnt = held_cnt + 1'b1;
		if (poll_cnt != '1) poll_cnt = poll_cnt + 1'b1;

		usb_rise = usb && !usb_prev;
		usb_fall = !usb && usb_prev;
		usb_prev = usb;

		if (poll_cnt > period_reg) begin
			pressed  = btn && !btn_prev;
			released = !btn && btn_prev;
			poll_cnt = '0;
			btn_prev = btn;
			if (ignore_btn) begin
				if (released) ignore_btn = 1'b0;
			end else if (pressed) begin
				held_cnt = '0;
			end else if (released) begin
				short_p = 1'b1;
			end else if (btn && held_cnt > long_reg) begin
				long_p     = 1'b1;
				ignore_btn = 1'b1;
			end
		end

		if (long_p) seq_state = SEQ_PO2;

		case (seq_state)
			SEQ_PW0: begin
				phase_cnt = '0;
				seq_state = SEQ_PW1;
			end
			SEQ_PW1: begin
				if (usb_fall) seq_state = SEQ_PO2;
				else if (phase_cnt > powerwait_reg) seq_state = SEQ_PON;
			end
			SEQ_PON: begin
				enable_q  = 1'b1;
				seq_state = SEQ_BW0;
			end
			SEQ_BW0: begin
				phase_cnt = '0;
				seq_state = SEQ_BW1;
			end
			SEQ_BW1: begin
				if (phase_cnt > bootwait_reg) seq_state = SEQ_PO2;
				else if (boot_on) seq_state = SEQ_BOOT;
			end
			SEQ_BOOT: begin
				if (short_p || usb_fall) seq_state = SEQ_SD0;
				else if (!boot_on) seq_state = SEQ_PO0;
			end
			SEQ_SD0: begin
				shutdown_q = 1'b1;
				phase_cnt  = '0;
				seq_state  = SEQ_SD1;
			end
			SEQ_SD1: begin
				if (phase_cnt > shutdown_reg || !boot_on) seq_state = SEQ_PO0;
			end
			SEQ_PO0, SEQ_PO1: begin
				// Entering power-off runs the wait check within the same tick.
				if (seq_state == SEQ_PO0) begin
					shutdown_q = 1'b0;
					phase_cnt  = '0;
				end
				seq_state = SEQ_PO1;
				if (phase_cnt > poweroff_reg) seq_state = SEQ_PO2;
				else if (boot_on) seq_state = SEQ_BOOT;
			end
			SEQ_PO2: begin
				enable_q   = 1'b0;
				shutdown_q = 1'b0;
				seq_state  = SEQ_IDLE0;
			end
			SEQ_IDLE0, SEQ_IDLE1, SEQ_IDLE2: begin
				// The idle states fall through into one another within a tick.
				if (seq_state == SEQ_IDLE0) sleep_p = 1'b1;
				if (seq_state != SEQ_IDLE2) phase_cnt = '0;
				seq_state = SEQ_IDLE2;
				if (phase_cnt > idle_reg) seq_state = SEQ_IDLE0;
				else if (short_p && usb) seq_state = SEQ_PON;
				else if (usb_rise) seq_state = SEQ_PON;
			end
			default: begin
				seq_state = usb ? SEQ_PW0 : SEQ_PO2;
			end
		endcase

		res.enable_out       = enable_q;
		res.shutdown_out     = shutdown_q;
		res.sleep_request    = sleep_p;
		res.state_code       = seq_state;
		res.short_press_seen = short_p;
		res.long_press_seen  = long_p;
	endtask

	task automatic compare_field(input string name, input logic [STATE_W-1:0] want,
			input logic [STATE_W-1:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want, fresh;
		if (!arst_n) begin
			reset_sequencer();
			expected_q.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_BUTTON_PERIOD: period_reg    = cfg_data[PERIOD_W-1:0];
					CFG_LONG_PRESS:    long_reg      = cfg_data;
					CFG_POWERWAIT:     powerwait_reg = cfg_data;
					CFG_BOOTWAIT:      bootwait_reg  = cfg_data;
					CFG_SHUTDOWN:      shutdown_reg  = cfg_data;
					CFG_POWEROFF:      poweroff_reg  = cfg_data;
					CFG_IDLE:          idle_reg      = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					errors++;
					$display("%0t: result transaction with no tick pending, actual state %0d",
						$time, state_code);
				end else begin
					want = expected_q.pop_front();
					compare_field("enable_out", want.enable_out, enable_out);
					compare_field("shutdown_out", want.shutdown_out, shutdown_out);
					compare_field("sleep_request", want.sleep_request, sleep_request);
					compare_field("state_code", want.state_code, state_code);
					compare_field("short_press_seen", want.short_press_seen, short_press_seen);
					compare_field("long_press_seen", want.long_press_seen, long_press_seen);
				end
			end
			if (in_valid && in_ready) begin
				predict_tick(usb_level, button_down, boot_level, fresh);
				expected_q.push_back(fresh);
			end
			pending = expected_q.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Power sequencer testbench
// Drives millisecond ticks into the power sequencer through a series of
// timing settings, from the reset values through the all-zero and all-ones
// extremes to many small random settings. Input levels follow runs shaped to
// the current timeouts so that the sequencer walks its whole cycle, with some
// noise mixed in. The sender idles in bursts and the receiver stalls at
// random; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
	import psb_pkg::*;

	localparam int unsigned STALL_LIMIT = 2000;
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic                  usb_level;
	logic                  button_down;
	logic                  boot_level;
	logic                  out_valid;
	logic                  out_ready;
	logic                  enable_out;
	logic                  shutdown_out;
	logic                  sleep_request;
	logic [STATE_W-1:0]    state_code;
	logic                  short_press_seen;
	logic                  long_press_seen;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int unsigned fail_count;
	int unsigned pending_results;
	int unsigned quiet_cycles = 0;

	int gap_max    = 0;
	int burst_left = 0;
	int stall_odds = 0;
	int stall_max  = 1;
	int stall_left = 0;

	logic [PERIOD_W-1:0] cur_period;
	logic [TICKS_W-1:0]  cur_long, cur_span;

	logic usb_lvl  = 1'b0;
	logic btn_lvl  = 1'b0;
	logic boot_lvl = 1'b0;
	int   usb_run  = 0;
	int   btn_run  = 0;
	int   boot_run = 0;

	// Bit order of a directed tick: usb level, button, boot level.
	localparam logic [2:0] DIRECTED_TICKS [20] = '{
		3'b101, 3'b101, 3'b101, 3'b101, 3'b100, 3'b110, 3'b100, 3'b100, 3'b101, 3'b100,
		3'b000, 3'b001, 3'b101, 3'b111, 3'b111, 3'b111, 3'b011, 3'b001, 3'b010, 3'b000
	};

	power_sequencer_with_button i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.usb_level        (usb_level),
		.button_down      (button_down),
		.boot_level       (boot_level),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.enable_out       (enable_out),
		.shutdown_out     (shutdown_out),
		.sleep_request    (sleep_request),
		.state_code       (state_code),
		.short_press_seen (short_press_seen),
		.long_press_seen  (long_press_seen),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	psb_checker i_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.usb_level        (usb_level),
		.button_down      (button_down),
		.boot_level       (boot_level),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.enable_out       (enable_out),
		.shutdown_out     (shutdown_out),
		.sleep_request    (sleep_request),
		.state_code       (state_code),
		.short_press_seen (short_press_seen),
		.long_press_seen  (long_press_seen),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.errors           (fail_count),
		.pending          (pending_results)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (stall_odds > 0 && $urandom_range(1, 100) <= stall_odds) begin
			out_ready  <= 1'b0;
			stall_left <= $urandom_range(0, stall_max - 1);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send_tick(input logic usb, input logic btn, input logic boot);
		if (burst_left == 0) begin
			if (gap_max > 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, gap_max)) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_valid    <= 1'b1;
		usb_level   <= usb;
		button_down <= btn;
		boot_level  <= boot;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid   <= 1'b0;
		burst_left = 0;
		while (pending_results != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic apply_timing(input logic [PERIOD_W-1:0] period, input logic [TICKS_W-1:0] long_t,
			input logic [TICKS_W-1:0] pw, input logic [TICKS_W-1:0] bw,
			input logic [TICKS_W-1:0] sd, input logic [TICKS_W-1:0] po,
			input logic [TICKS_W-1:0] idle_t);
		settle();
		write_reg(CFG_BUTTON_PERIOD, {6'($urandom), period});
		write_reg(CFG_LONG_PRESS, long_t);
		write_reg(CFG_POWERWAIT, pw);
		write_reg(CFG_BOOTWAIT, bw);
		write_reg(CFG_SHUTDOWN, sd);
		write_reg(CFG_POWEROFF, po);
		write_reg(CFG_IDLE, idle_t);
		write_reg(CFG_UNMAPPED, 16'($urandom));
		cfg_valid <= 1'b0;
		cur_period = period;
		cur_long   = long_t;
		cur_span   = pw;
		if (bw > cur_span) cur_span = bw;
		if (sd > cur_span) cur_span = sd;
		if (po > cur_span) cur_span = po;
		if (idle_t > cur_span) cur_span = idle_t;
	endtask

	task automatic run_random(input int count);
		int span, press_unit, long_hold;
		span       = (cur_span > 40) ? 40 : ((cur_span < 2) ? 2 : int'(cur_span));
		press_unit = (cur_period > 49) ? 50 : int'(cur_period) + 1;
		long_hold  = (cur_long > 250) ? 300 : int'(cur_long) + 2 * press_unit + 2;
		for (int i = 0; i < count; i++) begin
			if (usb_run <= 0) begin
				usb_lvl = !usb_lvl;
				usb_run = usb_lvl ? $urandom_range(1, 4 * span) : $urandom_range(1, span / 2 + 1);
			end
			if (btn_run <= 0) begin
				btn_lvl = !btn_lvl;
				if (!btn_lvl) btn_run = press_unit * $urandom_range(1, 4);
				else if ($urandom_range(0, 4) == 0) btn_run = long_hold;
				else btn_run = press_unit * $urandom_range(1, 3);
			end
			if (boot_run <= 0) begin
				boot_lvl = !boot_lvl;
				boot_run = $urandom_range(1, 2 * span);
			end
			if ($urandom_range(0, 9) == 0) begin
				send_tick(1'($urandom), 1'($urandom), 1'($urandom));
			end else begin
				send_tick(usb_lvl, btn_lvl, boot_lvl);
			end
			usb_run--;
			btn_run--;
			boot_run--;
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		usb_level   = 1'b0;
		button_down = 1'b0;
		boot_level  = 1'b0;
		out_ready   = 1'b1;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < 3; i++) begin
			send_tick(DIRECTED_TICKS[i][2], DIRECTED_TICKS[i][1], DIRECTED_TICKS[i][0]);
		end
		apply_timing('0, '0, '0, '0, '0, '0, '0);
		for (int i = 3; i < 20; i++) begin
			send_tick(DIRECTED_TICKS[i][2], DIRECTED_TICKS[i][1], DIRECTED_TICKS[i][0]);
		end

		for (int phase = 0; phase < 9; phase++) begin
			gap_max    = (phase % 3 == 0) ? 0 : $urandom_range(2, 8);
			stall_odds = (phase % 4 == 1) ? 0 : $urandom_range(5, 40);
			stall_max  = $urandom_range(1, 10);
			case (phase)
				0: begin
					apply_timing('1, '1, '1, '1, '1, '1, '1);
					run_random(40);
				end
				1: begin
					apply_timing(10'd1000, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
					run_random(40);
				end
				2: begin
					apply_timing(10'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
					run_random(100);
				end
				default: begin
					apply_timing(10'($urandom_range(0, 3)), 16'($urandom_range(0, 15)),
						16'($urandom_range(0, 30)), 16'($urandom_range(0, 30)),
						16'($urandom_range(0, 30)), 16'($urandom_range(0, 30)),
						16'($urandom_range(0, 30)));
					run_random(100);
				end
			endcase
		end

		settle();
		repeat (4) @(posedge clk);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
